/* rtl/tpt_pkg.sv */
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared sizes, request and result types for the page translation block.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int TLB_ENTRIES = 32;
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int COUNT_W     = $clog2(TLB_ENTRIES + 1);
    localparam int NUM_FRAMES  = 256;
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int PAGE_W      = 12;
    localparam int NUM_PAGES   = 1 << PAGE_W;
    localparam int OFFSET_W    = 12;
    localparam int ADDR_W      = PAGE_W + OFFSET_W;
    localparam int PHYS_W      = FRAME_W + OFFSET_W;
    localparam int STAMP_W     = 32;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_number;
        logic [OFFSET_W-1:0] page_offset;
        logic                tlb_hit;
        logic                page_fault;
        logic [FRAME_W-1:0]  frame_number;
        logic [PHYS_W-1:0]   physical_address;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page;
        logic                tlb_flushed;
        logic [COUNT_W-1:0]  tlb_count_after_flush;
        logic                tlb_victim_valid;
        logic [PAGE_W-1:0]   tlb_victim_page;
    } t_res;

endpackage

/* rtl/tpt_front.sv */
// ----------------------------------------------------------------------------
// tpt_front
// Accepts logical addresses, splits them into page and offset and queues
// the requests for the translation engine.
// ----------------------------------------------------------------------------
module tpt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [tpt_pkg::ADDR_W-1:0]  i_addr,
    input  logic                        i_hold,
    output logic                        o_full,
    output logic                        o_req_valid,
    output tpt_pkg::t_req               o_req,
    input  logic                        i_req_take
);
    import tpt_pkg::*;

    t_req       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_mem[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr].page   <= i_addr[ADDR_W-1:OFFSET_W];
            r_mem[r_wr].offset <= i_addr[OFFSET_W-1:0];
        end
    end

endmodule

/* rtl/tpt_back.sv */
// ----------------------------------------------------------------------------
// tpt_back
// Translation engine: TLB lookup, page table read, FIFO frame replacement,
// TLB flush and LRU fill.
// ----------------------------------------------------------------------------
module tpt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tlb_enable,
    input  logic           i_req_valid,
    input  tpt_pkg::t_req  i_req,
    output logic           o_req_take,
    input  logic           i_room,
    output logic           o_push,
    output tpt_pkg::t_res  o_res,
    output logic           o_clearing
);
    import tpt_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PT    = 3'd2;
    localparam logic [2:0] S_MAP   = 3'd3;
    localparam logic [2:0] S_LRU   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             r_state;
    logic [PAGE_W-1:0]      r_clr;
    logic [STAMP_W-1:0]     r_counter;
    logic [FRAME_W-1:0]     r_next_frame;

    logic [FRAME_W:0]       r_pt [NUM_PAGES];
    logic [FRAME_W:0]       r_pt_q;
    logic                   w_pt_we;
    logic [PAGE_W-1:0]      w_pt_waddr;
    logic [FRAME_W:0]       w_pt_wdata;

    logic [PAGE_W-1:0]      r_own [NUM_FRAMES];
    logic [PAGE_W-1:0]      r_own_q;
    logic [NUM_FRAMES-1:0]  r_own_valid;

    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [PAGE_W-1:0]      r_tlb_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [STAMP_W-1:0]     r_tlb_stamp [TLB_ENTRIES];

    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_W-1:0]    r_offset;
    logic [STAMP_W-1:0]     r_stamp;
    logic                   r_hit;
    logic                   r_fault;
    logic [FRAME_W-1:0]     r_frame;
    logic                   r_ev_valid;
    logic [PAGE_W-1:0]      r_ev_page;
    logic                   r_flushed;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_vic_valid;
    logic [PAGE_W-1:0]      r_vic_page;
    logic [TLB_IDX_W-1:0]   r_scan;
    logic [TLB_IDX_W-1:0]   r_best;
    logic [STAMP_W-1:0]     r_best_stamp;

    logic                   w_hit;
    logic [TLB_IDX_W-1:0]   w_hit_idx;
    logic                   w_free;
    logic [TLB_IDX_W-1:0]   w_free_idx;
    logic [COUNT_W-1:0]     w_count;
    logic [TLB_IDX_W-1:0]   w_lru_pos;
    logic                   w_take;
    logic                   w_fill;
    logic [TLB_IDX_W-1:0]   w_fill_pos;
    logic [TLB_ENTRIES-1:0] w_flush_mask;
    logic                   w_evict;

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        w_free    = 1'b0;
        w_free_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_tag[i] == i_req.page)) begin
                w_hit     = 1'b1;
                w_hit_idx = TLB_IDX_W'(i);
            end
            if (!r_tlb_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = TLB_IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_flush_mask[i] = r_tlb_valid[i] && (r_tlb_tag[i] == r_own_q);
        end
    end

    assign w_count   = COUNT_W'($countones(r_tlb_valid));
    assign w_lru_pos = (r_tlb_stamp[r_scan] < r_best_stamp) ? r_scan : r_best;
    assign w_take    = (r_state == S_IDLE) && i_req_valid && i_room;
    assign w_evict   = !r_pt_q[FRAME_W] && r_own_valid[r_next_frame];

    assign o_req_take = w_take;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_push     = (r_state == S_DONE);

    always_comb begin
        w_fill     = 1'b0;
        w_fill_pos = w_free_idx;
        if ((r_state == S_MAP) && i_tlb_enable && w_free) begin
            w_fill = 1'b1;
        end
        if ((r_state == S_LRU) && (r_scan == TLB_IDX_W'(TLB_ENTRIES - 1))) begin
            w_fill     = 1'b1;
            w_fill_pos = w_lru_pos;
        end
    end

    always_comb begin
        w_pt_we    = 1'b0;
        w_pt_waddr = r_page;
        w_pt_wdata = {1'b1, r_frame};
        unique case (r_state)
            S_CLEAR: begin
                w_pt_we    = 1'b1;
                w_pt_waddr = r_clr;
                w_pt_wdata = '0;
            end
            S_PT: begin
                w_pt_we    = w_evict;
                w_pt_waddr = r_own_q;
                w_pt_wdata = '0;
            end
            S_MAP: begin
                w_pt_we = r_fault;
            end
            default: begin
                w_pt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pt_we) r_pt[w_pt_waddr] <= w_pt_wdata;
        r_pt_q  <= r_pt[i_req.page];
        if ((r_state == S_PT) && !r_pt_q[FRAME_W]) r_own[r_next_frame] <= r_page;
        r_own_q <= r_own[r_next_frame];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_counter    <= '0;
            r_next_frame <= '0;
            r_own_valid  <= '0;
            r_tlb_valid  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PAGE_W'(NUM_PAGES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_counter <= r_counter + 1'b1;
                        r_state   <= (i_tlb_enable && w_hit) ? S_DONE : S_PT;
                    end
                end
                S_PT: begin
                    if (!r_pt_q[FRAME_W]) begin
                        r_own_valid[r_next_frame] <= 1'b1;
                        r_next_frame <= (r_next_frame == FRAME_W'(NUM_FRAMES - 1)) ?
                                        '0 : r_next_frame + 1'b1;
                        if (w_evict) r_tlb_valid <= r_tlb_valid & ~w_flush_mask;
                    end
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    if (!i_tlb_enable || w_free) r_state <= S_DONE;
                    else                          r_state <= S_LRU;
                end
                S_LRU: begin
                    if (w_fill) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_fill) r_tlb_valid[w_fill_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_tlb_tag[w_fill_pos]   <= r_page;
            r_tlb_frame[w_fill_pos] <= r_frame;
            r_tlb_stamp[w_fill_pos] <= r_stamp;
        end else if (w_take && i_tlb_enable && w_hit) begin
            r_tlb_stamp[w_hit_idx] <= r_counter;
        end
        case (r_state)
            S_IDLE: begin
                r_page      <= i_req.page;
                r_offset    <= i_req.offset;
                r_stamp     <= r_counter;
                r_hit       <= i_tlb_enable && w_hit;
                r_fault     <= 1'b0;
                r_frame     <= r_tlb_frame[w_hit_idx];
                r_ev_valid  <= 1'b0;
                r_ev_page   <= '0;
                r_flushed   <= 1'b0;
                r_count     <= w_count;
                r_vic_valid <= 1'b0;
                r_vic_page  <= '0;
            end
            S_PT: begin
                if (r_pt_q[FRAME_W]) begin
                    r_frame <= r_pt_q[FRAME_W-1:0];
                end else begin
                    r_frame    <= r_next_frame;
                    r_fault    <= 1'b1;
                    r_ev_valid <= w_evict;
                    r_ev_page  <= w_evict ? r_own_q : '0;
                    r_flushed  <= w_evict && (w_flush_mask != '0);
                end
            end
            S_MAP: begin
                r_count      <= w_count;
                r_scan       <= TLB_IDX_W'(1);
                r_best       <= '0;
                r_best_stamp <= r_tlb_stamp[0];
            end
            S_LRU: begin
                r_scan       <= r_scan + 1'b1;
                r_best       <= w_lru_pos;
                r_best_stamp <= r_tlb_stamp[w_lru_pos];
                if (w_fill) begin
                    r_vic_valid <= 1'b1;
                    r_vic_page  <= r_tlb_tag[w_lru_pos];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.page_number           = r_page;
        o_res.page_offset           = r_offset;
        o_res.tlb_hit               = r_hit;
        o_res.page_fault            = r_fault;
        o_res.frame_number          = r_frame;
        o_res.physical_address      = {r_frame, r_offset};
        o_res.evicted_valid         = r_ev_valid;
        o_res.evicted_page          = r_ev_page;
        o_res.tlb_flushed           = r_flushed;
        o_res.tlb_count_after_flush = r_count;
        o_res.tlb_victim_valid      = r_vic_valid;
        o_res.tlb_victim_page       = r_vic_page;
    end

endmodule

/* rtl/tpt_out.sv */
// ----------------------------------------------------------------------------
// tpt_out
// Two-entry result queue between the translation engine and the consumer.
// ----------------------------------------------------------------------------
module tpt_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpt_pkg::t_res  i_res,
    output logic           o_room,
    output logic           o_empty,
    input  logic           i_pop,
    output tpt_pkg::t_res  o_res
);
    import tpt_pkg::*;

    t_res       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_room  = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_res;
    end

endmodule

/* rtl/tlb_page_translation.sv */
// ----------------------------------------------------------------------------
// tlb_page_translation
// Logical to physical page translation with a 32-entry LRU TLB, a
// direct-indexed page table and round-robin frame replacement.
// ----------------------------------------------------------------------------
// channel   ports                               handshake
// request   i_logical_address                   i_push, o_full
// result    o_page_number ... o_tlb_victim_page o_empty, i_pop
// config    i_tlb_enable                        i_tlb_enable_we
//
// A TLB hit goes from idle straight to done; a miss passes the page table and
// map states, and a miss into a full TLB also the one-entry-per-cycle LRU
// stamp scan. After reset the page table is cleared while o_full is high.
// Two-entry queues on both sides let input and output stall independently.
// ----------------------------------------------------------------------------
module tlb_page_translation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tlb_enable_we,
    input  logic                                i_tlb_enable,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [tpt_pkg::ADDR_W-1:0]          i_logical_address,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [tpt_pkg::PAGE_W-1:0]          o_page_number,
    output logic [tpt_pkg::OFFSET_W-1:0]        o_page_offset,
    output logic                                o_tlb_hit,
    output logic                                o_page_fault,
    output logic [tpt_pkg::FRAME_W-1:0]         o_frame_number,
    output logic [tpt_pkg::PHYS_W-1:0]          o_physical_address,
    output logic                                o_evicted_valid,
    output logic [tpt_pkg::PAGE_W-1:0]          o_evicted_page,
    output logic                                o_tlb_flushed,
    output logic [tpt_pkg::COUNT_W-1:0]         o_tlb_count_after_flush,
    output logic                                o_tlb_victim_valid,
    output logic [tpt_pkg::PAGE_W-1:0]          o_tlb_victim_page
);
    import tpt_pkg::*;

    logic r_tlb_enable;
    logic w_req_valid;
    t_req w_req;
    logic w_req_take;
    logic w_room;
    logic w_push;
    t_res w_res_in;
    t_res w_res;
    logic w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_tlb_enable <= 1'b1;
        else if (i_tlb_enable_we) r_tlb_enable <= i_tlb_enable;
    end

    tpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_addr      (i_logical_address),
        .i_hold      (w_clearing),
        .o_full      (o_full),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_take  (w_req_take)
    );

    tpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tlb_enable (r_tlb_enable),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_req_take   (w_req_take),
        .i_room       (w_room),
        .o_push       (w_push),
        .o_res        (w_res_in),
        .o_clearing   (w_clearing)
    );

    tpt_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res_in),
        .o_room  (w_room),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (w_res)
    );

    assign o_page_number           = w_res.page_number;
    assign o_page_offset           = w_res.page_offset;
    assign o_tlb_hit               = w_res.tlb_hit;
    assign o_page_fault            = w_res.page_fault;
    assign o_frame_number          = w_res.frame_number;
    assign o_physical_address      = w_res.physical_address;
    assign o_evicted_valid         = w_res.evicted_valid;
    assign o_evicted_page          = w_res.evicted_page;
    assign o_tlb_flushed           = w_res.tlb_flushed;
    assign o_tlb_count_after_flush = w_res.tlb_count_after_flush;
    assign o_tlb_victim_valid      = w_res.tlb_victim_valid;
    assign o_tlb_victim_page       = w_res.tlb_victim_page;

endmodule
